### design/alm_pkg.sv
// Shared constants and types for the audio level meter.
package alm_pkg;

   localparam int DEF_RING_DEPTH = 32768;
   localparam int DEF_MAX_BLOCK  = 512;

   localparam int WORD_W   = 32;  // raw I2S word
   localparam int SAMPLE_W = 16;  // signed sample in the upper half of the word
   localparam int MAG_W    = 17;  // magnitude 0..32768
   localparam int SQ_W     = 31;  // square of the magnitude, at most 2^30
   localparam int RAD_W    = 32;  // radicand of the square root
   localparam int ROOT_W   = 16;  // square root result
   localparam int LEVEL_W  = 16;
   localparam int COUNT_W  = 32;
   localparam int RSP_W    = 112;

   typedef struct packed {
      logic [LEVEL_W-1:0] fill_level;
      logic [COUNT_W-1:0] overrun_total;
   } ring_status_type;

endpackage

### design/alm_ring.sv
// Overwriting sample ring store with occupancy and overrun tracking.
module alm_ring #(
   parameter int RING_DEPTH = alm_pkg::DEF_RING_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [alm_pkg::SAMPLE_W-1:0]   wr_data,
   output alm_pkg::ring_status_type       status
);
   import alm_pkg::*;

   localparam int POS_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int OCC_W = $clog2(RING_DEPTH + 1);

   logic [SAMPLE_W-1:0] store [RING_DEPTH];

   logic [POS_W-1:0]   wr_pos_ff, wr_pos_in;
   logic [POS_W-1:0]   old_pos_ff, old_pos_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic [COUNT_W-1:0] overrun_ff, overrun_in;
   logic               full;

   function automatic logic [POS_W-1:0] ring_next(input logic [POS_W-1:0] pos);
      return (pos == POS_W'(RING_DEPTH - 1)) ? '0 : pos + POS_W'(1);
   endfunction

   assign full = (occ_ff == OCC_W'(RING_DEPTH));

   always_comb begin
      wr_pos_in  = wr_pos_ff;
      old_pos_in = old_pos_ff;
      occ_in     = occ_ff;
      overrun_in = overrun_ff;
      if (wr_en) begin
         wr_pos_in = ring_next(wr_pos_ff);
         if (!full) begin
            occ_in = occ_ff + OCC_W'(1);
         end else begin
            // The newest sample has taken the place of the oldest one.
            old_pos_in = ring_next(old_pos_ff);
            overrun_in = overrun_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_pos_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff  <= '0;
         old_pos_ff <= '0;
         occ_ff     <= '0;
         overrun_ff <= '0;
      end else begin
         wr_pos_ff  <= wr_pos_in;
         old_pos_ff <= old_pos_in;
         occ_ff     <= occ_in;
         overrun_ff <= overrun_in;
      end
   end

   assign status.fill_level    = LEVEL_W'(occ_ff);
   assign status.overrun_total = overrun_ff;

endmodule

### design/alm_divsqrt.sv
// Shared compare-subtract unit that divides the block sum and then takes the square root.
module alm_divsqrt #(
   parameter int MAX_BLOCK = alm_pkg::DEF_MAX_BLOCK
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               start,
   input  logic [alm_pkg::SQ_W+$clog2(MAX_BLOCK+1)-1:0]       numer,
   input  logic [$clog2(MAX_BLOCK+1)-1:0]                     denom,
   output logic                                               done,
   output logic [alm_pkg::ROOT_W-1:0]                         root
);
   import alm_pkg::*;

   localparam int DEN_W = $clog2(MAX_BLOCK + 1);
   localparam int NUM_W = SQ_W + DEN_W;
   localparam int U_W   = (DEN_W + 1 > ROOT_W + 2) ? DEN_W + 1 : ROOT_W + 2;
   localparam int CNT_W = $clog2(NUM_W + 1);

   typedef enum logic [2:0] {
      DS_IDLE = 3'b001,
      DS_DIV  = 3'b010,
      DS_SQRT = 3'b100
   } ds_state_type;

   ds_state_type       state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               done_ff, done_in;
   logic [U_W-1:0]     rem_ff, rem_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [RAD_W-1:0]   rad_ff, rad_in;
   logic [ROOT_W-1:0]  root_ff, root_in;

   logic [U_W-1:0]     op_a, op_b;
   logic [U_W:0]       diff;
   logic               ge;

   // The one subtractor: a trial subtraction whose borrow decides the next bit.
   always_comb begin
      if (state_ff == DS_SQRT) begin
         op_a = {rem_ff[U_W-3:0], rad_ff[RAD_W-1:RAD_W-2]};
         op_b = U_W'({root_ff, 2'b01});
      end else begin
         op_a = {rem_ff[U_W-2:0], num_ff[NUM_W-1]};
         op_b = U_W'(den_ff);
      end
      diff = {1'b0, op_a} - {1'b0, op_b};
      ge   = ~diff[U_W];
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      rem_in   = rem_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rad_in   = rad_ff;
      root_in  = root_ff;
      unique case (state_ff)
         DS_IDLE: begin
            if (start) begin
               state_in = DS_DIV;
               count_in = CNT_W'(NUM_W - 1);
               rem_in   = '0;
               num_in   = numer;
               den_in   = denom;
            end
         end
         DS_DIV: begin
            rem_in = ge ? diff[U_W-1:0] : op_a;
            num_in = {num_ff[NUM_W-2:0], ge};
            if (count_ff == '0) begin
               // The mean square never exceeds 2^30, so its low word is the radicand.
               state_in = DS_SQRT;
               count_in = CNT_W'(ROOT_W - 1);
               rem_in   = '0;
               rad_in   = num_in[RAD_W-1:0];
               root_in  = '0;
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         DS_SQRT: begin
            rem_in  = ge ? diff[U_W-1:0] : op_a;
            root_in = {root_ff[ROOT_W-2:0], ge};
            rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
            if (count_ff == '0) begin
               state_in = DS_IDLE;
               done_in  = 1'b1;
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         default: begin
            state_in = DS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DS_IDLE;
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      rad_ff  <= rad_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

### design/audio_level_meter_ring_store_top.sv
// Top level of the audio level meter: sample accumulation, ring store and result register.
// An ordinary word passes through the square and accumulate states before the next word can be accepted.
// The last word of a block then runs the bit-serial division of the block sum and the square root
// in the shared divide and square root unit, and the result is loaded into the result register;
// a result still waiting to be taken holds off that load and so the next word.
// Reset is synchronous and active high; it clears all counters, accumulators and control state.
module audio_level_meter_ring_store_top #(
   parameter int RING_DEPTH = alm_pkg::DEF_RING_DEPTH,
   parameter int MAX_BLOCK  = alm_pkg::DEF_MAX_BLOCK
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [alm_pkg::WORD_W-1:0]   req_tdata,   // i2s_word
   input  logic                         req_tlast,   // block_end
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // rms_level, peak_level, samples_total, fill_level, overrun_total
   output logic [alm_pkg::RSP_W-1:0]    rsp_tdata
);
   import alm_pkg::*;

   localparam int LEN_W = $clog2(MAX_BLOCK + 1);
   localparam int SUM_W = SQ_W + LEN_W;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SQUARE = 5'b00010,
      S_ACCUM  = 5'b00100,
      S_CALC   = 5'b01000,
      S_LOAD   = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [SAMPLE_W-1:0]  sample_ff, sample_in;
   logic                 last_ff, last_in;
   logic [MAG_W-1:0]     mag_ff, mag_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [LEVEL_W-1:0]   peak_ff, peak_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [COUNT_W-1:0]   samples_ff, samples_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]     rsp_data_ff, rsp_data_in;

   logic                 accept;
   logic [LEN_W-1:0]     len_next;
   logic                 block_done;
   logic [2*MAG_W-1:0]   product;
   logic                 calc_start;
   logic                 calc_done;
   logic [ROOT_W-1:0]    root;
   logic                 ring_wr;
   ring_status_type      ring_status;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign len_next   = len_ff + LEN_W'(1);
   // A block that reaches its length limit closes as if the word carried the end mark.
   assign block_done = last_ff || (len_next == LEN_W'(MAX_BLOCK));
   assign product    = mag_ff * mag_ff;
   assign calc_start = (state_ff == S_ACCUM) && block_done;
   assign ring_wr    = (state_ff == S_ACCUM);

   always_comb begin
      state_in     = state_ff;
      sample_in    = sample_ff;
      last_in      = last_ff;
      mag_in       = mag_ff;
      sum_in       = sum_ff;
      peak_in      = peak_ff;
      len_in       = len_ff;
      samples_in   = samples_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               sample_in = req_tdata[WORD_W-1:WORD_W-SAMPLE_W];
               last_in   = req_tlast;
               state_in  = S_SQUARE;
            end
         end
         S_SQUARE: begin
            // The magnitude of the most negative sample is 32768, held in 17 bits.
            if (sample_ff[SAMPLE_W-1]) begin
               mag_in = MAG_W'(0) - {sample_ff[SAMPLE_W-1], sample_ff};
            end else begin
               mag_in = {1'b0, sample_ff};
            end
            state_in = S_ACCUM;
         end
         S_ACCUM: begin
            // The square of the registered magnitude goes straight into the sum.
            sum_in     = sum_ff + SUM_W'(product[SQ_W-1:0]);
            len_in     = len_next;
            samples_in = samples_ff + COUNT_W'(1);
            if (mag_ff[LEVEL_W-1:0] > peak_ff) begin
               peak_in = mag_ff[LEVEL_W-1:0];
            end
            state_in = block_done ? S_CALC : S_IDLE;
         end
         S_CALC: begin
            if (calc_done) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {ring_status.overrun_total, ring_status.fill_level,
                               samples_ff, peak_ff, LEVEL_W'(root)};
               sum_in       = '0;
               peak_in      = '0;
               len_in       = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         peak_ff      <= '0;
         len_ff       <= '0;
         samples_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         peak_ff      <= peak_in;
         len_ff       <= len_in;
         samples_ff   <= samples_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      last_ff     <= last_in;
      mag_ff      <= mag_in;
      rsp_data_ff <= rsp_data_in;
   end

   alm_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ring_wr),
      .wr_data (sample_ff),
      .status  (ring_status)
   );

   alm_divsqrt #(
      .MAX_BLOCK (MAX_BLOCK)
   ) u_divsqrt (
      .clock (clock),
      .reset (reset),
      .start (calc_start),
      .numer (sum_in),
      .denom (len_next),
      .done  (calc_done),
      .root  (root)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the audio level meter with its overwriting ring store.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import alm_pkg::*;

   localparam int RING_SIZE   = DEF_RING_DEPTH;
   localparam int BLOCK_LIMIT = DEF_MAX_BLOCK;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      bit [LEVEL_W-1:0] rms_level;
      bit [LEVEL_W-1:0] peak_level;
      bit [COUNT_W-1:0] samples_total;
      bit [LEVEL_W-1:0] fill_level;
      bit [COUNT_W-1:0] overrun_total;
   } meter_reading_type;

   class meter_scoreboard;
      longint unsigned   square_sum;
      int unsigned       peak_hold;
      int unsigned       block_words;
      int unsigned       occupancy;
      bit [COUNT_W-1:0]  overrun_count;
      bit [COUNT_W-1:0]  sample_count;
      meter_reading_type pending_levels[$];
      int unsigned       errors;
      int unsigned       readings_checked;
      int unsigned       cut_blocks;

      function new();
         square_sum    = 0;
         peak_hold     = 0;
         block_words   = 0;
         occupancy     = 0;
         overrun_count = 0;
         sample_count  = 0;
         errors        = 0;
         readings_checked = 0;
         cut_blocks    = 0;
      endfunction

      function int unsigned floor_root(longint unsigned v);
         longint unsigned root;
         longint unsigned trial;
         root = 0;
         for (int b = 16; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= v) begin
               root = trial;
            end
         end
         return int'(root);
      endfunction

      // Predicts the meter state after one accepted beat; a block end queues a reading.
      function void note_word(bit [WORD_W-1:0] word, bit block_end);
         int                sample;
         int unsigned       mag;
         meter_reading_type r;
         sample = $signed(word[31:16]);
         mag = (sample < 0) ? -sample : sample;
         square_sum += longint'(mag) * longint'(mag);
         if (mag > peak_hold) begin
            peak_hold = mag;
         end
         block_words++;
         sample_count++;
         // A full store still takes the write; the oldest entry is lost instead.
         if (occupancy < RING_SIZE) begin
            occupancy++;
         end else begin
            overrun_count++;
         end
         if (!block_end && block_words < BLOCK_LIMIT) begin
            return;
         end
         if (!block_end) begin
            cut_blocks++;
         end
         r.rms_level     = 16'(floor_root(square_sum / block_words));
         r.peak_level    = peak_hold[15:0];
         r.samples_total = sample_count;
         r.fill_level    = occupancy[15:0];
         r.overrun_total = overrun_count;
         pending_levels.push_back(r);
         square_sum  = 0;
         peak_hold   = 0;
         block_words = 0;
      endfunction

      function void report_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_result(bit [RSP_W-1:0] data);
         meter_reading_type want;
         if (pending_levels.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected reading, expected none, got %h", $time, data);
            return;
         end
         want = pending_levels.pop_front();
         readings_checked++;
         report_field("rms_level", want.rms_level, data[15:0]);
         report_field("peak_level", want.peak_level, data[31:16]);
         report_field("samples_total", want.samples_total, data[63:32]);
         report_field("fill_level", want.fill_level, data[79:64]);
         report_field("overrun_total", want.overrun_total, data[111:80]);
      endfunction

      function int unsigned pending();
         return pending_levels.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [WORD_W-1:0]  req_tdata;
   logic               req_tlast;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [RSP_W-1:0]   rsp_tdata;

   bit no_idle;
   bit stall_request;

   meter_scoreboard sb = new();

   audio_level_meter_ring_store_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #100ms;
      $display("FAIL audio_level_meter_ring_store_top");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_word(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata);
         end
      end
   end

   // Result side: random back-pressure, plus one long hold-off on request.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request) begin
            rsp_tready <= 1'b0;
            for (int i = 0; i < HOLD_CYCLES; i++) begin
               @(negedge clock);
            end
            stall_request = 1'b0;
         end
         rsp_tready <= !reset && (no_idle || $urandom_range(99) >= 28);
      end
   end

   task automatic send_word(input bit [WORD_W-1:0] word, input bit block_end);
      while (!no_idle && $urandom_range(99) < 28) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tlast  <= block_end;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   function automatic bit [WORD_W-1:0] random_word();
      bit [15:0] upper;
      case ($urandom_range(9))
         0: upper = 16'h8000;
         1: upper = 16'h7FFF;
         2: upper = 16'hFFFF;
         3: upper = 16'h0000;
         4: upper = 16'($signed($urandom_range(32)) - 16);
         default: upper = 16'($urandom);
      endcase
      return {upper, 16'($urandom)};
   endfunction

   // Most blocks are short; a few run past the block limit without an end marker.
   task automatic send_random_blocks(input int unsigned words);
      int unsigned sent;
      int unsigned span;
      int unsigned pick;
      sent = 0;
      while (sent < words) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            span = $urandom_range(600, 1);
         end else if (pick < 30) begin
            span = 1;
         end else begin
            span = $urandom_range(40, 2);
         end
         for (int unsigned i = 0; i < span; i++) begin
            send_word(random_word(), i == span - 1);
         end
         sent += span;
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      no_idle    = 1'b0;
      stall_request = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: silence, all ones, full scale of either sign, and mixed peaks.
      send_word(32'h0000_0000, 1'b1);
      send_word(32'hFFFF_FFFF, 1'b1);
      send_word(32'h7FFF_0000, 1'b1);
      for (int i = 0; i < 4; i++) begin
         send_word(32'h8000_FFFF, i == 3);
      end
      send_word(32'h7FFF_1234, 1'b0);
      send_word(32'h8000_0000, 1'b0);
      send_word(32'h0001_ABCD, 1'b1);
      send_word(32'h0001_5555, 1'b0);
      send_word(32'hFFFF_AAAA, 1'b0);
      send_word(32'h0000_FFFF, 1'b0);
      send_word(32'h8001_0001, 1'b1);
      send_word(32'h4000_8000, 1'b0);
      send_word(32'hC000_7FFF, 1'b1);

      // Short blocks while the result side holds off, so the input backs up.
      stall_request = 1'b1;
      send_random_blocks(450);

      // One long run without an end mark, cut at the block limit, mostly without gaps.
      for (int i = 0; i < BLOCK_LIMIT + 18; i++) begin
         no_idle = (i >= 100 && i < 450);
         send_word(random_word(), i == BLOCK_LIMIT + 17);
      end
      no_idle = 1'b0;

      send_random_blocks(450);
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (200) @(posedge clock);

      $display("Checked %0d readings over %0d words; %0d blocks were cut at the block limit.",
               sb.readings_checked, sb.sample_count, sb.cut_blocks);
      $display("The store ended holding %0d samples after %0d overwrites; full-scale peaks included.",
               sb.occupancy, sb.overrun_count);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASS audio_level_meter_ring_store_top");
      end else begin
         $display("FAIL audio_level_meter_ring_store_top");
      end
      $finish;
   end

endmodule

### sim.f
design/alm_pkg.sv
design/alm_ring.sv
design/alm_divsqrt.sv
design/audio_level_meter_ring_store_top.sv
tb/sv/testbench.sv
